FILE: sv/shcf_pkg.sv
`timescale 1ns / 1ps

package shcf_pkg;

	localparam int unsigned PAYLOAD_CAP = 4095;
	localparam int unsigned LEN_W       = 12;
	localparam int unsigned IDX_W       = 4;

	localparam logic [7:0]  SYNC_A     = 8'hAA;
	localparam logic [7:0]  SYNC_B     = 8'hBB;
	localparam logic [7:0]  CRC8_POLY  = 8'h07;
	localparam logic [15:0] CRC16_POLY = 16'hA001;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [7:0]  CMD_RESET  = 8'd62;

	typedef enum logic {
		OP_START   = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_DEV_ADDR = 2'd0,
		CFG_NEED_ACK = 2'd1,
		CFG_COMMAND  = 2'd2
	} cfg_idx_t;

	typedef enum logic [IDX_W-1:0] {
		BI_SYNC_A  = 4'd0,
		BI_SYNC_B  = 4'd1,
		BI_ROUTE   = 4'd2,
		BI_COMMAND = 4'd3,
		BI_SEQ     = 4'd4,
		BI_LEN_LO  = 4'd5,
		BI_LEN_HI  = 4'd6,
		BI_CRC8    = 4'd7,
		BI_TRL_LO  = 4'd8,
		BI_TRL_HI  = 4'd9
	} hdr_idx_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       frame_seq;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_item_t;

	function automatic logic [7:0] crc8_add(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_add(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: sv/shcf_if.sv
`timescale 1ns / 1ps

interface shcf_in_if;
	logic                valid;
	logic                ready;
	shcf_pkg::in_item_t  item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface shcf_out_if;
	logic                valid;
	logic                ready;
	shcf_pkg::out_item_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

FILE: sv/sync_header_crc_framer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// din       sink       valid/ready    op, frame_seq, payload_len, data_byte
// dout      source     valid/ready    out_byte, frame_end
// cfg       write      cfg_we         cfg_idx, cfg_data
//
// One output byte per cycle while dout is ready; a payload byte item emits its byte, the
// last one also two trailer bytes, a start item eight header bytes (and the trailer for
// zero length), bounded by the single output register. Dropped payload items emit no
// byte. arst_n clears the frame state and both valid flags and resets the config
// registers. A stalled dout holds the output register and any undropped input item.

module sync_header_crc_framer (
	input  logic               clk,
	input  logic               arst_n,
	shcf_in_if.sink            din,
	shcf_out_if.source         dout,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [7:0]         cfg_data
);

	logic [3:0]                   dev_addr_q;
	logic                         need_ack_q;
	logic [7:0]                   command_q;

	logic                         valid_s1;
	shcf_pkg::in_item_t           item_s1;
	logic                         valid_s2;
	shcf_pkg::out_item_t          item_s2;

	logic [15:0]                  crc_q;
	logic [7:0]                   crc8_q;
	logic [shcf_pkg::LEN_W-1:0]   left_q;
	logic                         open_q;
	logic [shcf_pkg::IDX_W-1:0]   idx_q;

	logic                         is_start;
	logic                         drop;
	logic                         trl_lo;
	logic                         trl_hi;
	logic                         last;
	logic                         out_free;
	logic                         emit;
	logic                         done;
	logic [7:0]                   cur_byte;
	logic [7:0]                   route;
	logic [15:0]                  crc_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= '0;
			need_ack_q <= 1'b0;
			command_q  <= shcf_pkg::CMD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				shcf_pkg::CFG_DEV_ADDR: dev_addr_q <= cfg_data[3:0];
				shcf_pkg::CFG_NEED_ACK: need_ack_q <= cfg_data[0];
				shcf_pkg::CFG_COMMAND:  command_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_start = (item_s1.op == shcf_pkg::OP_START);
	assign drop     = !is_start && (idx_q == '0) && (!open_q || (left_q == '0));
	assign trl_lo   = is_start ? (idx_q == shcf_pkg::BI_TRL_LO) : (idx_q == 4'd1);
	assign trl_hi   = is_start ? (idx_q == shcf_pkg::BI_TRL_HI) : (idx_q == 4'd2);
	assign route    = {1'b0, need_ack_q, 2'b00, dev_addr_q};
	assign crc_base = (is_start && (idx_q == '0)) ? shcf_pkg::CRC16_INIT : crc_q;

	always_comb begin
		if (is_start) begin
			last = (item_s1.payload_len == '0) ? (idx_q == shcf_pkg::BI_TRL_HI)
			                                   : (idx_q == shcf_pkg::BI_CRC8);
		end else begin
			last = (idx_q == '0) ? (left_q != 12'd1) : (idx_q == 4'd2);
		end
	end

	always_comb begin
		cur_byte = '0;
		if (is_start) begin
			case (idx_q)
				shcf_pkg::BI_SYNC_A:  cur_byte = shcf_pkg::SYNC_A;
				shcf_pkg::BI_SYNC_B:  cur_byte = shcf_pkg::SYNC_B;
				shcf_pkg::BI_ROUTE:   cur_byte = route;
				shcf_pkg::BI_COMMAND: cur_byte = command_q;
				shcf_pkg::BI_SEQ:     cur_byte = item_s1.frame_seq;
				shcf_pkg::BI_LEN_LO:  cur_byte = item_s1.payload_len[7:0];
				shcf_pkg::BI_LEN_HI:  cur_byte = {4'h0, item_s1.payload_len[11:8]};
				shcf_pkg::BI_CRC8:    cur_byte = crc8_q;
				shcf_pkg::BI_TRL_LO:  cur_byte = crc_q[7:0];
				shcf_pkg::BI_TRL_HI:  cur_byte = crc_q[15:8];
				default:              cur_byte = '0;
			endcase
		end else begin
			case (idx_q)
				4'd0:    cur_byte = item_s1.data_byte;
				4'd1:    cur_byte = crc_q[7:0];
				4'd2:    cur_byte = crc_q[15:8];
				default: cur_byte = '0;
			endcase
		end
	end

	assign out_free  = !valid_s2 || dout.ready;
	assign emit      = valid_s1 && !drop && out_free;
	assign done      = valid_s1 && (drop || (emit && last));
	assign din.ready = !valid_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			item_s1 <= din.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			crc_q  <= shcf_pkg::CRC16_INIT;
			crc8_q <= '0;
			left_q <= '0;
			open_q <= 1'b0;
		end else begin
			if (done) begin
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 4'd1;
			end
			if (emit) begin
				if (trl_hi) begin
					crc_q  <= shcf_pkg::CRC16_INIT;
					left_q <= '0;
					open_q <= 1'b0;
				end else if (!trl_lo) begin
					crc_q <= shcf_pkg::crc16_add(crc_base, cur_byte);
				end
				if (is_start && (idx_q < shcf_pkg::BI_CRC8)) begin
					crc8_q <= shcf_pkg::crc8_add((idx_q == '0) ? 8'h00 : crc8_q, cur_byte);
				end
				if (is_start && (idx_q == shcf_pkg::BI_CRC8)) begin
					left_q <= item_s1.payload_len;
					open_q <= 1'b1;
				end
				if (!is_start && (idx_q == '0)) begin
					left_q <= left_q - 12'd1;
				end
			end
		end
	end

	// hold the output register until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			item_s2.out_byte  <= cur_byte;
			item_s2.frame_end <= trl_hi;
		end
	end

	assign dout.valid = valid_s2;
	assign dout.item  = item_s2;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= shcf_pkg::BI_TRL_HI)
		else $error("byte index out of range");

	a_idx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> valid_s1)
		else $error("byte index advanced with no item held");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (left_q == '0))
		else $error("bytes left while no frame open");

	a_close_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && trl_hi) |=> (crc_q == shcf_pkg::CRC16_INIT) && !open_q)
		else $error("frame not closed after trailer");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && trl_hi) |-> done)
		else $error("trailer high byte did not finish the item");

endmodule
